[rtl/pdi_pkg.sv]
package pdi_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int COORD_BITS = 15;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int ROOT_BITS  = 16;

  // The restoring root settles one bit per step, starting from the highest
  // even bit position of the sum of squares.
  localparam int ROOT_STEPS     = DIFF_BITS;
  localparam int ROOT_START_BIT = SQ_BITS - 2;
  localparam int CNT_BITS       = $clog2(ROOT_STEPS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [ROOT_BITS-1:0]         root_t;

  // Commands from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic load_in;
    logic square;
    logic sum;
    logic step;
    logic out_load;
  } cmd_t;

endpackage

[rtl/pdi_if.sv]
interface pdi_in_if;
  logic            valid;
  logic            ready;
  pdi_pkg::coord_t first_x;
  pdi_pkg::coord_t first_y;
  pdi_pkg::coord_t second_x;
  pdi_pkg::coord_t second_y;

  modport source (output valid, output first_x, output first_y,
                  output second_x, output second_y, input ready);
  modport sink   (input valid, input first_x, input first_y,
                  input second_x, input second_y, output ready);
endinterface

interface pdi_out_if;
  logic           valid;
  logic           ready;
  pdi_pkg::root_t distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

[rtl/pdi_ctrl.sv]
module pdi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pdi_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_SUM    = 5'b00100,
    S_ROOT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [pdi_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == pdi_pkg::CNT_BITS'(pdi_pkg::ROOT_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/pdi_dp.sv]
module pdi_dp (
  input  logic            clk,
  input  pdi_pkg::cmd_t   cmd,
  input  pdi_pkg::coord_t first_x,
  input  pdi_pkg::coord_t first_y,
  input  pdi_pkg::coord_t second_x,
  input  pdi_pkg::coord_t second_y,
  output pdi_pkg::root_t  distance
);

  pdi_pkg::diff_t dx_r, dy_r;
  pdi_pkg::sq_t   sqx_r, sqy_r;
  pdi_pkg::sq_t   rem_r, root_r, bit_r;
  pdi_pkg::root_t dist_r;

  logic signed [pdi_pkg::SQ_BITS-1:0] sqx_full, sqy_full;
  pdi_pkg::sq_t                       trial;
  logic                               fits;

  // Squares of the differences are never negative, so the signed product
  // can be taken as an unsigned value.
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  assign trial = root_r + bit_r;
  assign fits  = (rem_r >= trial);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx_r <= pdi_pkg::DIFF_BITS'(second_x) - pdi_pkg::DIFF_BITS'(first_x);
      dy_r <= pdi_pkg::DIFF_BITS'(second_y) - pdi_pkg::DIFF_BITS'(first_y);
    end
    if (cmd.square) begin
      sqx_r <= pdi_pkg::sq_t'(sqx_full);
      sqy_r <= pdi_pkg::sq_t'(sqy_full);
    end
    if (cmd.sum) begin
      rem_r  <= sqx_r + sqy_r;
      root_r <= '0;
      bit_r  <= pdi_pkg::sq_t'(1) << pdi_pkg::ROOT_START_BIT;
    end else if (cmd.step) begin
      if (fits) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.out_load) begin
      dist_r <= root_r[pdi_pkg::ROOT_BITS-1:0];
    end
  end

  assign distance = dist_r;

endmodule

[rtl/point_distance_isqrt_core.sv]
// Integer Euclidean distance between two points.
//
// The input channel carries one pair of points per transfer (first_x,
// first_y, second_x, second_y, signed). The result channel carries the floor
// of the square root of dx*dx + dy*dy, where each difference is second minus
// first. Both channels use a valid/ready handshake.
//
// The transfer edge registers the differences; the core then squares them,
// adds the squares, runs the sixteen-step restoring square root one root bit
// per cycle, and moves the root into the output register once that register
// is free. The core is idle again in the cycle after that move, and it takes
// no new input before then, so one item is in flight.
//
// The result sits in an output register, so the next input can be accepted
// while an earlier result still waits on a stalled receiver. If the receiver
// still holds off when the next root is done, the core waits and accepts no
// input until the output register frees up. Reset (rst_n, synchronous,
// active low) returns the controller to idle and drops the output valid.
module point_distance_isqrt_core (
  input  logic      clk,
  input  logic      rst_n,
  pdi_in_if.sink    in_ch,
  pdi_out_if.source out_ch
);

  pdi_pkg::cmd_t cmd;

  // The controller sequences one item at a time and owns both handshakes.
  pdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath holds the differences, squares, root iteration registers
  // and the output register.
  pdi_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .first_x  (in_ch.first_x),
    .first_y  (in_ch.first_y),
    .second_x (in_ch.second_x),
    .second_y (in_ch.second_y),
    .distance (out_ch.distance)
  );

  // An accepted item keeps the core busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while busy");

  // A new result never overwrites one the receiver has not taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.square, cmd.sum, cmd.step, cmd.out_load}))
    else $error("conflicting datapath commands");

  // Summing the squares is always followed by the first root step.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum |=> cmd.step)
    else $error("root loop did not start after sum");

endmodule

[sim/pdi_distance_checker.sv]
// Watches both channels of the distance core. Every input transfer gets its
// expected distance computed here; every result transfer is compared with the
// oldest expectation still waiting.
module pdi_distance_checker (
  input  logic clk,
  input  logic rst_n,
  pdi_in_if    in_mon,
  pdi_out_if   out_mon,
  output int   mismatch_count,
  output int   pending_count
);

  // Highest power of four that the root search may start from.
  localparam logic [31:0] ROOT_SEARCH_START = 32'h4000_0000;

  typedef struct {
    pdi_pkg::coord_t fx;
    pdi_pkg::coord_t fy;
    pdi_pkg::coord_t sx;
    pdi_pkg::coord_t sy;
    pdi_pkg::root_t  distance;
  } pair_result_t;

  pair_result_t pending_distances[$];
  pair_result_t oldest;
  int           error_tally = 0;

  // Floor of the Euclidean distance, using the bit-pair restoring root.
  function automatic pdi_pkg::root_t floor_distance(pdi_pkg::coord_t fx, pdi_pkg::coord_t fy,
                                                    pdi_pkg::coord_t sx, pdi_pkg::coord_t sy);
    pdi_pkg::diff_t dx;
    pdi_pkg::diff_t dy;
    logic [31:0]    remainder;
    logic [31:0]    root;
    logic [31:0]    pair_bit;
    dx = sx - fx;
    dy = sy - fy;
    remainder = dx * dx + dy * dy;
    root = '0;
    pair_bit = ROOT_SEARCH_START;
    while (pair_bit > remainder)
      pair_bit = pair_bit >> 2;
    while (pair_bit != 0) begin
      if (remainder >= root + pair_bit) begin
        remainder = remainder - (root + pair_bit);
        root = root + (pair_bit << 1);
      end
      root = root >> 1;
      pair_bit = pair_bit >> 2;
    end
    return root[pdi_pkg::ROOT_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    error_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_distances.delete();
      pending_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        pending_distances.push_back('{in_mon.first_x, in_mon.first_y,
                                      in_mon.second_x, in_mon.second_y,
                                      floor_distance(in_mon.first_x, in_mon.first_y,
                                                     in_mon.second_x, in_mon.second_y)});
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_distances.size() == 0) begin
          report_mismatch($sformatf("distance %0d arrived with no input waiting",
                                    out_mon.distance));
        end else begin
          oldest = pending_distances.pop_front();
          if (out_mon.distance !== oldest.distance)
            report_mismatch($sformatf("(%0d,%0d)->(%0d,%0d): distance %0d, wanted %0d",
                                      oldest.fx, oldest.fy, oldest.sx, oldest.sy,
                                      out_mon.distance, oldest.distance));
        end
      end
      pending_count <= pending_distances.size();
    end
    mismatch_count <= error_tally;
  end

endmodule

[sim/point_distance_isqrt_core_test.sv]
// Top of the distance core bench. It makes the clock and reset, drives point
// pairs into the input channel, paces the result channel, and gives the
// verdict. All prediction and comparison lives in the checker beside the core.
module point_distance_isqrt_core_test;

  // The receiver alternates between segments of these kinds.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_JITTER,
    RX_HOLD
  } rx_mode_t;

  localparam int RANDOM_PAIRS = 1500;
  // Cycles to linger once nothing is expected.
  localparam int DRAIN_CYCLES = 60;
  localparam int CMIN = -16384;
  localparam int CMAX = 16383;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   expected_left;

  pdi_in_if  in_ch ();
  pdi_out_if out_ch ();

  point_distance_isqrt_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pdi_distance_checker dist_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatches),
    .pending_count  (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle gap in cycles: usually none or a few, now and then a long one.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    else if (pick < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 60);
  endfunction

  // Offers one point pair and returns after the edge at which it transfers.
  // Each coordinate keeps its low bits only. While the sender idles, the
  // payload carries junk so that the core is seen to ignore it when valid
  // is low.
  task automatic offer_pair(input int fx, input int fy,
                            input int sx, input int sy);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid    <= 1'b0;
      in_ch.first_x  <= pdi_pkg::coord_t'($urandom);
      in_ch.first_y  <= pdi_pkg::coord_t'($urandom);
      in_ch.second_x <= pdi_pkg::coord_t'($urandom);
      in_ch.second_y <= pdi_pkg::coord_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= pdi_pkg::coord_t'(fx);
    in_ch.first_y  <= pdi_pkg::coord_t'(fy);
    in_ch.second_x <= pdi_pkg::coord_t'(sx);
    in_ch.second_y <= pdi_pkg::coord_t'(sy);
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
  endtask

  // One coordinate drawn from the ends of the range, their neighbors, and -1, 0, 1.
  function automatic int corner_coord();
    case ($urandom_range(0, 6))
      0:       return CMIN;
      1:       return -16383;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 16382;
      default: return CMAX;
    endcase
  endfunction

  // Receiver pacing. Shortly after reset it holds off for a long stretch
  // while the sender keeps offering, so the output register fills, the next
  // root completes behind it and the core has to stop taking input. After
  // that it moves through steady, jittery and held segments at random.
  initial begin
    rx_mode_t mode;
    int       budget;
    int       run;
    logic     level;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n)
      @(posedge clk);
    repeat (60) begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
    end
    @(negedge clk);
    out_ch.ready <= 1'b0;
    repeat (299) @(negedge clk);
    forever begin
      case ($urandom_range(0, 19))
        0:             mode = RX_HOLD;
        1, 2, 3, 4, 5: mode = RX_STEADY;
        default:       mode = RX_JITTER;
      endcase
      budget = $urandom_range(50, 400);
      case (mode)
        RX_STEADY: begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
          repeat (budget - 1) @(negedge clk);
        end
        RX_HOLD: begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
          repeat (budget - 1) @(negedge clk);
        end
        default: begin
          // Short runs of ready and stall, with a long stall now and then.
          while (budget > 0) begin
            level = 1'($urandom_range(0, 1));
            if (level)
              run = $urandom_range(1, 8);
            else if ($urandom_range(0, 9) == 0)
              run = $urandom_range(10, 40);
            else
              run = $urandom_range(1, 3);
            @(negedge clk);
            out_ch.ready <= level;
            repeat (run - 1) @(negedge clk);
            budget -= run;
          end
        end
      endcase
    end
  end

  // Stimulus and verdict.
  initial begin
    int fx, fy, sx, sy;
    int pick;
    int base_x, base_y;
    in_ch.valid    = 1'b0;
    in_ch.first_x  = '0;
    in_ch.first_y  = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Equal points, including the corners of the range, give zero.
    offer_pair(0, 0, 0, 0);
    offer_pair(CMIN, CMIN, CMIN, CMIN);
    offer_pair(CMAX, CMAX, CMAX, CMAX);
    offer_pair(-1, -1, -1, -1);
    // Largest differences on both axes, in all four diagonal directions.
    offer_pair(CMIN, CMIN, CMAX, CMAX);
    offer_pair(CMAX, CMAX, CMIN, CMIN);
    offer_pair(CMAX, CMIN, CMIN, CMAX);
    offer_pair(CMIN, CMAX, CMAX, CMIN);
    // A large difference on one axis only, up to the largest, and the largest with one unit on the other.
    offer_pair(0, 0, CMAX, 0);
    offer_pair(0, CMIN, 0, CMAX);
    offer_pair(CMIN, 0, CMAX, 1);
    // Tiny sums, where the root search shifts far down.
    offer_pair(0, 0, 1, 0);
    offer_pair(0, 0, 1, 1);
    offer_pair(0, 0, 2, 0);
    offer_pair(100, 100, 99, 98);
    // Exact and near squares, signs mixed.
    offer_pair(0, 0, 3, 4);
    offer_pair(-1, -1, 2, 3);
    offer_pair(5, -7, -7, 9);
    offer_pair(0, 0, 181, 181);
    offer_pair(0, 0, 255, 256);
    // Alternating bit patterns in every coordinate.
    offer_pair('h2AAA, 'h5555, 'h5555, 'h2AAA);
    offer_pair('h5555, 'h2AAA, 'h2AAA, 'h5555);

    // Random part: mostly full range, plus near neighbors and range corners.
    repeat (RANDOM_PAIRS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        fx = $urandom;
        fy = $urandom;
        sx = $urandom;
        sy = $urandom;
      end else if (pick < 85) begin
        base_x = $urandom_range(0, 32000) - 16000;
        base_y = $urandom_range(0, 32000) - 16000;
        fx = base_x;
        fy = base_y;
        sx = base_x + $urandom_range(0, 600) - 300;
        sy = base_y + $urandom_range(0, 600) - 300;
      end else begin
        fx = corner_coord();
        fy = corner_coord();
        sx = corner_coord();
        sy = corner_coord();
      end
      offer_pair(fx, fy, sx, sy);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait until every expected distance has been taken, then linger so that
    // any stray extra result would still be seen.
    repeat (2) @(posedge clk);
    while (expected_left != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_left == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog, far beyond what a full run needs even under long receiver stalls.
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/pdi_pkg.sv
rtl/pdi_if.sv
rtl/pdi_ctrl.sv
rtl/pdi_dp.sv
rtl/point_distance_isqrt_core.sv
sim/pdi_distance_checker.sv
sim/point_distance_isqrt_core_test.sv
